// ----- rtl/lzcse_pkg.sv -----
// lzcse_pkg: types, command codes, range limits and helper functions
// for the LZ command symbol emitter; depends on nothing
package lzcse_pkg;

    localparam int COUNT_BITS = 21;
    localparam logic [COUNT_BITS-1:0] HIST_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [3:0] {
        CMD_LITERAL   = 4'd0,
        CMD_INSERT    = 4'd1,
        CMD_COPY      = 4'd2,
        CMD_COPY_LAST = 4'd3,
        CMD_DISTANCE  = 4'd4,
        CMD_LAST_SYM  = 4'd5,
        CMD_LOAD_LIT  = 4'd6,
        CMD_LOAD_CMD  = 4'd7,
        CMD_BLOCK     = 4'd8,
        CMD_HIST_READ = 4'd9
    } t_cmd;

    // range limits of the length classes
    localparam logic [24:0] INS_LIM_SHORT = 25'd130;
    localparam logic [24:0] INS_LIM_MID   = 25'd2114;
    localparam logic [24:0] INS_LIM_12    = 25'd6210;
    localparam logic [24:0] INS_LIM_14    = 25'd22594;
    localparam logic [24:0] CPY_LIM_SHORT = 25'd134;
    localparam logic [24:0] CPY_LIM_MID   = 25'd2118;
    localparam logic [24:0] CPL_LIM_SHORT = 25'd72;
    localparam logic [24:0] CPL_LIM_5     = 25'd136;
    localparam logic [24:0] CPL_LIM_MID   = 25'd2120;
    localparam logic [24:0] EXTRA_MAX     = 25'h0FFFFFF;
    localparam logic [6:0]  SYM_LAST_DIST = 7'd64;

    typedef struct packed {
        logic [3:0]  command;
        logic [7:0]  byte_value;
        logic [24:0] length;
        logic [23:0] distance;
        logic [7:0]  table_index;
        logic [3:0]  code_length;
        logic [15:0] code_word;
    } t_in;

    typedef struct packed {
        logic [4:0]  bit_count;
        logic [23:0] bit_value;
        logic [20:0] histogram_count;
        logic        last;
    } t_out;

    // decoded item waiting for its table and histogram reads
    typedef struct packed {
        logic        lit;
        logic        hrd;
        logic        hoor;
        logic        sym;
        logic        ext;
        logic        s64;
        logic        bump;
        logic        b64;
        logic        h64;
        logic        blk;
        logic [4:0]  ext_cnt;
        logic [23:0] ext_val;
        logic [6:0]  haddr;
    } t_stage;

    function automatic logic [4:0] floor_log2(input logic [24:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 1; i < 25; i++) begin
            if (v[i]) r = 5'(i);
        end
        return r;
    endfunction

    function automatic t_out put_bits(input logic [4:0] cnt, input logic [23:0] val);
        t_out o;
        o.bit_count = cnt;
        o.bit_value = (cnt >= 5'd24) ? val : (val & ((24'd1 << cnt) - 24'd1));
        o.histogram_count = '0;
        o.last = 1'b0;
        return o;
    endfunction

    // start-of-block histogram pattern
    function automatic logic [COUNT_BITS-1:0] hist_init(input logic [6:0] idx);
        logic z;
        z = (idx == 7'd0) || (idx >= 7'd16 && idx <= 7'd18) || (idx == 7'd40) ||
            (idx >= 7'd65 && idx <= 7'd79) || (idx >= 7'd124);
        return z ? '0 : COUNT_BITS'(1);
    endfunction

endpackage

// ----- rtl/lz_command_symbol_emitter.sv -----
// lz_command_symbol_emitter: top level, decode, table and histogram access
// depends on lzcse_pkg and lzcse_ram
//
// One item is taken per cycle when not stalled and turned into up to three
// bit-field writes (prefix code, extra bits, last-distance code); an item
// waits while earlier results drain, so the sustained rate is one result per
// cycle while i_stall is low, set by the three-entry output buffer. The item
// is decoded on entry, the code tables and the histogram are read in the same
// cycle, and the results and the histogram update are formed from the
// registered item, with the update forwarded to a following item that reads
// the same entry. Block start clears per-entry valid bits, so the histogram is
// back to its start pattern at once. No clearing pass is needed after reset.
module lz_command_symbol_emitter
    import lzcse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    logic                  in_xfer, out_xfer, fire;
    t_stage                d, r_s;
    logic                  r_svld;
    logic [6:0]            code, hidx;
    logic [24:0]           v, lc, dd;
    logic [4:0]            nb;
    logic [19:0]           cmd_q, lit_q, r_c64;
    logic [COUNT_BITS-1:0] hist_q, h_cur, h_new, h64_new, r_h64, r_fwdd;
    logic                  r_fwd;
    logic [127:0]          r_hvld;
    t_out                  res [3];
    t_out                  r_ob [3];
    logic [1:0]            nres, r_ocnt;

    assign o_valid  = (r_ocnt != 2'd0);
    assign o_data   = r_ob[0];
    assign out_xfer = o_valid && !i_stall;
    assign fire     = r_svld && ((r_ocnt == 2'd0) || (r_ocnt == 2'd1 && out_xfer));
    assign o_stall  = r_svld && !fire;
    assign in_xfer  = i_valid && !o_stall;

    // decode
    always_comb begin
        d    = '0;
        code = '0;
        hidx = '0;
        v    = '0;
        nb   = '0;
        lc   = (i_data.length < 25'd4) ? 25'd4 : i_data.length;
        dd   = ((i_data.distance == 24'd0) ? 25'd1 : {1'b0, i_data.distance}) + 25'd3;
        unique case (i_data.command)
            CMD_LITERAL: d.lit = 1'b1;
            CMD_INSERT: begin
                d.sym = 1'b1;
                if (i_data.length < 25'd6) begin
                    code = 7'd40 + 7'(i_data.length[2:0]);
                end else if (i_data.length < INS_LIM_SHORT) begin
                    v    = i_data.length - 25'd2;
                    nb   = floor_log2(v) - 5'd1;
                    code = 7'd42 + 7'({nb, 1'b0}) + 7'(v >> nb);
                    d.ext = 1'b1;
                end else if (i_data.length < INS_LIM_MID) begin
                    v    = i_data.length - 25'd66;
                    nb   = floor_log2(v);
                    code = 7'd50 + 7'(nb);
                    d.ext = 1'b1;
                end else if (i_data.length < INS_LIM_12) begin
                    v = i_data.length - INS_LIM_MID; nb = 5'd12; code = 7'd61; d.ext = 1'b1;
                end else if (i_data.length < INS_LIM_14) begin
                    v = i_data.length - INS_LIM_12; nb = 5'd14; code = 7'd62; d.ext = 1'b1;
                end else begin
                    v  = i_data.length - INS_LIM_14;
                    v  = (v > EXTRA_MAX) ? EXTRA_MAX : v;
                    nb = 5'd24; code = 7'd63; d.ext = 1'b1;
                end
                // the wide classes count at a different histogram slot
                hidx = (code >= 7'd61) ? code - 7'd40 : code;
            end
            CMD_COPY: begin
                d.sym = 1'b1;
                if (i_data.length < 25'd10) begin
                    code = 7'd14 + 7'(i_data.length[3:0]);
                end else if (i_data.length < CPY_LIM_SHORT) begin
                    v    = i_data.length - 25'd6;
                    nb   = floor_log2(v) - 5'd1;
                    code = 7'd20 + 7'({nb, 1'b0}) + 7'(v >> nb);
                    d.ext = 1'b1;
                end else if (i_data.length < CPY_LIM_MID) begin
                    v    = i_data.length - 25'd70;
                    nb   = floor_log2(v);
                    code = 7'd28 + 7'(nb);
                    d.ext = 1'b1;
                end else begin
                    v  = i_data.length - CPY_LIM_MID;
                    v  = (v > EXTRA_MAX) ? EXTRA_MAX : v;
                    nb = 5'd24; code = 7'd39; d.ext = 1'b1;
                end
                hidx = (code == 7'd39) ? 7'd47 : code;
            end
            CMD_COPY_LAST: begin
                d.sym = 1'b1;
                if (lc < 25'd12) begin
                    code = 7'(lc[3:0]) - 7'd4;
                end else if (lc < CPL_LIM_SHORT) begin
                    v    = lc - 25'd8;
                    nb   = floor_log2(v) - 5'd1;
                    code = 7'd4 + 7'({nb, 1'b0}) + 7'(v >> nb);
                    d.ext = 1'b1;
                end else if (lc < CPL_LIM_5) begin
                    v    = lc - 25'd8;
                    nb   = 5'd5;
                    code = 7'd30 + 7'(v >> 5);
                    d.ext = 1'b1;
                end else if (lc < CPL_LIM_MID) begin
                    v    = lc - 25'd72;
                    nb   = floor_log2(v);
                    code = 7'd28 + 7'(nb);
                    d.ext = 1'b1;
                end else begin
                    v  = lc - CPL_LIM_MID;
                    v  = (v > EXTRA_MAX) ? EXTRA_MAX : v;
                    nb = 5'd24; code = 7'd39; d.ext = 1'b1;
                end
                d.s64 = (lc >= CPL_LIM_SHORT);
                d.b64 = d.s64;
                hidx  = (code == 7'd39) ? 7'd47 : code;
            end
            CMD_DISTANCE: begin
                d.sym = 1'b1;
                d.ext = 1'b1;
                v     = dd;
                nb    = floor_log2(dd) - 5'd1;
                code  = 7'd78 + 7'({nb, 1'b0}) + 7'(dd[nb]);
                hidx  = code;
            end
            CMD_LAST_SYM: begin
                d.s64 = 1'b1;
                d.b64 = 1'b1;
            end
            CMD_HIST_READ: begin
                d.hrd  = 1'b1;
                d.hoor = i_data.table_index[7];
                d.h64  = (i_data.table_index[6:0] == SYM_LAST_DIST);
                hidx   = i_data.table_index[6:0];
            end
            CMD_BLOCK: d.blk = 1'b1;
            default: ;
        endcase
        d.bump    = d.sym;
        d.ext_cnt = nb;
        d.ext_val = v[23:0];
        d.haddr   = hidx;
    end

    lzcse_ram #(.WIDTH(20), .DEPTH(128)) u_cmd_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer && i_data.command == CMD_LOAD_CMD && !i_data.table_index[7]),
        .i_waddr (i_data.table_index[6:0]),
        .i_wdata ({i_data.code_length, i_data.code_word}),
        .i_re    (in_xfer),
        .i_raddr (code),
        .o_rdata (cmd_q)
    );

    lzcse_ram #(.WIDTH(20), .DEPTH(256)) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer && i_data.command == CMD_LOAD_LIT),
        .i_waddr (i_data.table_index),
        .i_wdata ({i_data.code_length, i_data.code_word}),
        .i_re    (in_xfer),
        .i_raddr (i_data.byte_value),
        .o_rdata (lit_q)
    );

    lzcse_ram #(.WIDTH(COUNT_BITS), .DEPTH(128)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (fire && r_s.bump),
        .i_waddr (r_s.haddr),
        .i_wdata (h_new),
        .i_re    (in_xfer),
        .i_raddr (d.haddr),
        .o_rdata (hist_q)
    );

    // histogram value seen by the waiting item
    always_comb begin
        if (r_s.h64) begin
            h_cur = r_h64;
        end else if (!r_hvld[r_s.haddr]) begin
            h_cur = hist_init(r_s.haddr);
        end else if (r_fwd) begin
            h_cur = r_fwdd;
        end else begin
            h_cur = hist_q;
        end
        h_new   = (h_cur == HIST_MAX) ? h_cur : h_cur + COUNT_BITS'(1);
        h64_new = (r_h64 == HIST_MAX) ? r_h64 : r_h64 + COUNT_BITS'(1);
    end

    // result list for the waiting item
    always_comb begin
        res[0] = '0;
        res[1] = '0;
        res[2] = '0;
        nres   = 2'd0;
        if (r_s.lit) begin
            res[nres] = put_bits({1'b0, lit_q[19:16]}, {8'd0, lit_q[15:0]});
            nres = nres + 2'd1;
        end
        if (r_s.hrd) begin
            res[nres] = '0;
            res[nres].histogram_count = r_s.hoor ? '0 : 21'(h_cur);
            nres = nres + 2'd1;
        end
        if (r_s.sym) begin
            res[nres] = put_bits({1'b0, cmd_q[19:16]}, {8'd0, cmd_q[15:0]});
            nres = nres + 2'd1;
        end
        if (r_s.ext) begin
            res[nres] = put_bits(r_s.ext_cnt, r_s.ext_val);
            nres = nres + 2'd1;
        end
        if (r_s.s64) begin
            res[nres] = put_bits({1'b0, r_c64[19:16]}, {8'd0, r_c64[15:0]});
            nres = nres + 2'd1;
        end
        if (nres != 2'd0) begin
            res[nres - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svld <= 1'b0;
            r_ocnt <= 2'd0;
            r_hvld <= '0;
            r_h64  <= COUNT_BITS'(1);
            r_fwd  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_svld <= 1'b1;
                // same entry written by the item leaving now
                r_fwd  <= fire && r_s.bump && (r_s.haddr == d.haddr);
            end else if (fire) begin
                r_svld <= 1'b0;
            end
            if (fire) begin
                r_ocnt <= nres;
                if (r_s.bump) begin
                    r_hvld[r_s.haddr] <= 1'b1;
                end
                if (r_s.b64) begin
                    r_h64 <= h64_new;
                end
                if (r_s.blk) begin
                    r_hvld <= '0;
                    r_h64  <= COUNT_BITS'(1);
                end
            end else if (out_xfer) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s    <= d;
            r_fwdd <= h_new;
            if (i_data.command == CMD_LOAD_CMD && i_data.table_index == 8'd64) begin
                r_c64 <= {i_data.code_length, i_data.code_word};
            end
        end
        if (fire) begin
            r_ob <= res;
        end else if (out_xfer) begin
            r_ob[0] <= r_ob[1];
            r_ob[1] <= r_ob[2];
        end
    end
endmodule

// ----- rtl/lzcse_ram.sv -----
// lzcse_ram: generic single-write, single-read memory with registered read
// no package dependency
module lzcse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

// ----- rtl/lzcse_chk.sv -----
// lzcse_chk: port-level checks for the LZ command symbol emitter
// depends on lzcse_pkg; bound to the top level below
module lzcse_chk
    import lzcse_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);
    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a stalled transfer keeps its result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // histogram counts only travel on zero-width writes
    a_hist_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.histogram_count != 21'd0 |->
            o_data.bit_count == 5'd0 && o_data.bit_value == 24'd0)
        else $error("histogram count on a bit write");

    // bit value never carries bits above bit_count
    a_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.bit_count < 5'd24 |->
            (o_data.bit_value >> o_data.bit_count) == 24'd0)
        else $error("unmasked bit value");
endmodule

bind lz_command_symbol_emitter lzcse_chk u_lzcse_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
